[hw/rtl/cat_pkg.sv]
// ============================================================================
// cat_pkg
// Shared constants, codes, sequencer states and a helper for the CSR
// adjacency table.
// ============================================================================
`default_nettype none

package cat_pkg;

    localparam int NODE_W    = 10;      // node index
    localparam int NCNT_W    = 11;      // node count, 1..1024
    localparam int EIDX_W    = 12;      // column store address
    localparam int ECNT_W    = 13;      // edge count / offset, 0..4096
    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 4096;

    // request actions
    localparam logic [2:0] ACT_INSERT   = 3'd0;
    localparam logic [2:0] ACT_CONTAINS = 3'd1;
    localparam logic [2:0] ACT_CLR_ROW  = 3'd2;
    localparam logic [2:0] ACT_CLR_COL  = 3'd3;
    localparam logic [2:0] ACT_CLR_ALL  = 3'd4;
    localparam logic [2:0] ACT_READ     = 3'd5;
    localparam logic [2:0] ACT_DEGREE   = 3'd6;

    // result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_INS_HI_RD,
        S_INS_HI_CAP,
        S_INS_SH_RD,
        S_INS_SH_WR,
        S_INS_PUT,
        S_INS_OFF_RD,
        S_INS_OFF_WR,
        S_F_LO_RD,
        S_F_LO_CAP,
        S_F_HI_RD,
        S_F_HI_CAP,
        S_CT_RD,
        S_CT_CMP,
        S_RE_CAP,
        S_DG_RD,
        S_DG_CMP,
        S_CR_RD,
        S_CR_WR,
        S_CR_OFF_RD,
        S_CR_OFF_WR,
        S_CC_ROW,
        S_CC_HI,
        S_CC_RD,
        S_CC_CHK,
        S_DONE
    } seq_state_t;

    // Row offset lookup: row 0 always starts at 0, rows at or past the node
    // count start at the edge total, the rest come from the offset RAM.
    function automatic logic [ECNT_W-1:0] row_off(
        input logic [NCNT_W-1:0] idx,
        input logic [NCNT_W-1:0] nodes,
        input logic [ECNT_W-1:0] edges,
        input logic [ECNT_W-1:0] ram_q
    );
        logic [ECNT_W-1:0] v;
        if (idx == '0) v = '0;
        else if (idx >= nodes) v = edges;
        else v = ram_q;
        return v;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/cat_ram.sv]
// ============================================================================
// cat_ram
// Generic single write / single read port RAM with registered read data.
// ============================================================================
`default_nettype none

module cat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/csr_adjacency_table.sv]
// ============================================================================
// csr_adjacency_table
// Directed graph in compressed sparse row form: row offset RAM, column
// store RAM and a node count, one sequencer serving one request at a time.
// ============================================================================
//
//  channel   dir  tdata                                   tuser
//  s_        in   row_node, col_node, entry_pos (32b)     action (3b)
//  m_        out  found, entry_col, out_degree, in_degree,
//                 node_count, edge_count (64b)            status (2b)
//
// Each column store or offset step is a RAM read then a compare or write.
// Insert and clear-row step through the entries moved and the rows
// adjusted, degree through every edge, clear-column through every edge
// and every row. s_tready is high only while idle, and a finished result
// waits in the output register while the next request is taken. Reset is
// synchronous, active low; offsets past the node count follow the edge total.
`default_nettype none

module csr_adjacency_table
    import cat_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // row_node, col_node, entry_pos
    input  wire logic [2:0]  s_tuser,   // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [63:0] m_tdata,   // found, entry_col, out_degree,
                                        // in_degree, node_count, edge_count
    output logic      [1:0]  m_tuser    // status
);

    seq_state_t state_reg, state_next;

    logic [2:0]        act_reg, act_next;
    logic [NODE_W-1:0] row_reg, row_next, col_reg, col_next;
    logic [EIDX_W-1:0] pos_reg, pos_next;
    logic [NCNT_W-1:0] nodes_reg, nodes_next, nnew_reg, nnew_next;
    logic [NCNT_W-1:0] r_reg, r_next, rem_reg, rem_next;
    logic [ECNT_W-1:0] edges_reg, edges_next;
    logic [ECNT_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [ECNT_W-1:0] i_reg, i_next, w_reg, w_next;
    logic [ECNT_W-1:0] odeg_reg, odeg_next, ideg_reg, ideg_next;
    logic              hit_reg, hit_next, found_reg, found_next;
    logic [NODE_W-1:0] entry_reg, entry_next;
    logic [1:0]        status_reg, status_next;
    logic              mv_reg, mv_next;
    logic [63:0]       md_reg, md_next;
    logic [1:0]        mu_reg, mu_next;

    // RAM ports
    logic              off_we;
    logic [NODE_W-1:0] off_waddr, off_raddr;
    logic [ECNT_W-1:0] off_wdata, off_q;
    logic              cs_we;
    logic [EIDX_W-1:0] cs_waddr, cs_raddr;
    logic [NODE_W-1:0] cs_wdata, cs_q;

    cat_ram #(.WIDTH(ECNT_W), .DEPTH(MAX_NODES)) u_off (
        .aclk  (aclk),
        .we    (off_we),
        .waddr (off_waddr),
        .wdata (off_wdata),
        .raddr (off_raddr),
        .rdata (off_q)
    );

    cat_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_cs (
        .aclk  (aclk),
        .we    (cs_we),
        .waddr (cs_waddr),
        .wdata (cs_wdata),
        .raddr (cs_raddr),
        .rdata (cs_q)
    );

    // shared decode terms
    logic [NCNT_W-1:0] row_x, col_x, row_p1;
    logic              bad_r, bad_c, full;
    logic [ECNT_W-1:0] lo_val, hi_val, len_val, cc_hi_val;
    logic [ECNT_W-1:0] pos_x;
    logic              out_free, s_acc;

    assign row_x     = {1'b0, row_reg};
    assign col_x     = {1'b0, col_reg};
    assign row_p1    = row_x + 1'b1;
    assign bad_r     = row_x >= nodes_reg;
    assign bad_c     = col_x >= nodes_reg;
    assign full      = edges_reg >= ECNT_W'(MAX_EDGES);
    assign lo_val    = row_off(row_x, nodes_reg, edges_reg, off_q);
    assign hi_val    = row_off(row_p1, nodes_reg, edges_reg, off_q);
    assign cc_hi_val = row_off(r_reg + 1'b1, nodes_reg, edges_reg, off_q);
    assign len_val   = hi_val - lo_reg;
    assign pos_x     = {1'b0, pos_reg};
    assign out_free  = !mv_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:       if (s_acc) state_next = S_DECODE;
            S_DECODE: begin
                unique case (act_reg)
                    ACT_INSERT:   state_next = full ? S_DONE : S_INS_HI_RD;
                    ACT_CONTAINS,
                    ACT_DEGREE:   state_next = (bad_r || bad_c) ? S_DONE : S_F_LO_RD;
                    ACT_CLR_ROW,
                    ACT_READ:     state_next = bad_r ? S_DONE : S_F_LO_RD;
                    ACT_CLR_COL:  state_next = bad_c ? S_DONE : S_CC_ROW;
                    default:      state_next = S_DONE;
                endcase
            end
            S_INS_HI_RD:  state_next = S_INS_HI_CAP;
            S_INS_HI_CAP: state_next = S_INS_SH_RD;
            S_INS_SH_RD:  state_next = (i_reg > hi_reg) ? S_INS_SH_WR : S_INS_PUT;
            S_INS_SH_WR:  state_next = S_INS_SH_RD;
            S_INS_PUT:    state_next = S_INS_OFF_RD;
            S_INS_OFF_RD: state_next = (r_reg < nnew_reg) ? S_INS_OFF_WR : S_DONE;
            S_INS_OFF_WR: state_next = S_INS_OFF_RD;
            S_F_LO_RD:    state_next = S_F_LO_CAP;
            S_F_LO_CAP:   state_next = S_F_HI_RD;
            S_F_HI_RD:    state_next = S_F_HI_CAP;
            S_F_HI_CAP: begin
                unique case (act_reg)
                    ACT_CONTAINS: state_next = S_CT_RD;
                    ACT_CLR_ROW:  state_next = S_CR_RD;
                    ACT_READ:     state_next = (pos_x < len_val) ? S_RE_CAP : S_DONE;
                    default:      state_next = S_DG_RD;
                endcase
            end
            S_CT_RD:      state_next = (i_reg < hi_reg) ? S_CT_CMP : S_DONE;
            S_CT_CMP:     state_next = S_CT_RD;
            S_RE_CAP:     state_next = S_DONE;
            S_DG_RD:      state_next = (i_reg < edges_reg) ? S_DG_CMP : S_DONE;
            S_DG_CMP:     state_next = S_DG_RD;
            S_CR_RD:      state_next = (i_reg < edges_reg) ? S_CR_WR : S_CR_OFF_RD;
            S_CR_WR:      state_next = S_CR_RD;
            S_CR_OFF_RD:  state_next = (r_reg < nodes_reg) ? S_CR_OFF_WR : S_DONE;
            S_CR_OFF_WR:  state_next = S_CR_OFF_RD;
            S_CC_ROW:     state_next = (r_reg < nodes_reg) ? S_CC_HI : S_DONE;
            S_CC_HI:      state_next = S_CC_RD;
            S_CC_RD:      state_next = (i_reg < hi_reg) ? S_CC_CHK : S_CC_ROW;
            S_CC_CHK:     state_next = S_CC_RD;
            S_DONE:       if (out_free) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        act_next    = act_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        pos_next    = pos_reg;
        nodes_next  = nodes_reg;
        nnew_next   = nnew_reg;
        r_next      = r_reg;
        rem_next    = rem_reg;
        edges_next  = edges_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        i_next      = i_reg;
        w_next      = w_reg;
        odeg_next   = odeg_reg;
        ideg_next   = ideg_reg;
        hit_next    = hit_reg;
        found_next  = found_reg;
        entry_next  = entry_reg;
        status_next = status_reg;
        mv_next     = mv_reg;
        md_next     = md_reg;
        mu_next     = mu_reg;
        off_we      = 1'b0;
        off_waddr   = r_reg[NODE_W-1:0];
        off_wdata   = '0;
        off_raddr   = r_reg[NODE_W-1:0];
        cs_we       = 1'b0;
        cs_waddr    = w_reg[EIDX_W-1:0];
        cs_wdata    = cs_q;
        cs_raddr    = i_reg[EIDX_W-1:0];

        // output register drains independently
        if (mv_reg && m_tready) mv_next = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    row_next    = s_tdata[9:0];
                    col_next    = s_tdata[19:10];
                    pos_next    = s_tdata[31:20];
                    act_next    = s_tuser;
                    found_next  = 1'b0;
                    entry_next  = '0;
                    odeg_next   = '0;
                    ideg_next   = '0;
                    status_next = ST_OK;
                end
            end
            S_DECODE: begin
                unique case (act_reg)
                    ACT_INSERT: begin
                        if (full) begin
                            status_next = ST_FULL;
                        end else begin
                            nnew_next = nodes_reg;
                            if (row_p1 > nnew_next) nnew_next = row_p1;
                            if (col_x + 1'b1 > nnew_next) nnew_next = col_x + 1'b1;
                        end
                    end
                    ACT_CONTAINS, ACT_DEGREE: begin
                        if (bad_r || bad_c) status_next = ST_RANGE;
                    end
                    ACT_CLR_ROW, ACT_READ: begin
                        if (bad_r) status_next = ST_RANGE;
                    end
                    ACT_CLR_COL: begin
                        if (bad_c) begin
                            status_next = ST_RANGE;
                        end else begin
                            r_next   = '0;
                            lo_next  = '0;
                            rem_next = '0;
                            w_next   = '0;
                        end
                    end
                    ACT_CLR_ALL: begin
                        nodes_next = NCNT_W'(1);
                        edges_next = '0;
                    end
                    default: status_next = ST_RANGE;
                endcase
            end
            // insert: find end of row, open a slot, fix offsets
            S_INS_HI_RD: off_raddr = row_p1[NODE_W-1:0];
            S_INS_HI_CAP: begin
                hi_next = hi_val;
                i_next  = edges_reg;
            end
            S_INS_SH_RD: cs_raddr = EIDX_W'(i_reg - 1'b1);
            S_INS_SH_WR: begin
                cs_we    = 1'b1;
                cs_waddr = i_reg[EIDX_W-1:0];
                cs_wdata = cs_q;
                i_next   = i_reg - 1'b1;
            end
            S_INS_PUT: begin
                cs_we    = 1'b1;
                cs_waddr = hi_reg[EIDX_W-1:0];
                cs_wdata = col_reg;
                r_next   = (nodes_reg < row_p1) ? nodes_reg : row_p1;
            end
            S_INS_OFF_RD: begin
                if (r_reg >= nnew_reg) begin
                    edges_next = edges_reg + 1'b1;
                    nodes_next = nnew_reg;
                end
            end
            S_INS_OFF_WR: begin
                off_we = 1'b1;
                if (r_reg >= nodes_reg) begin
                    off_wdata = edges_reg + ((r_reg >= row_p1) ? 13'd1 : 13'd0);
                end else begin
                    off_wdata = off_q + 1'b1;
                end
                r_next = r_reg + 1'b1;
            end
            // fetch row bounds
            S_F_LO_RD: off_raddr = row_reg;
            S_F_LO_CAP: lo_next = lo_val;
            S_F_HI_RD: off_raddr = row_p1[NODE_W-1:0];
            S_F_HI_CAP: begin
                hi_next = hi_val;
                unique case (act_reg)
                    ACT_CONTAINS: i_next = lo_reg;
                    ACT_CLR_ROW: begin
                        i_next = hi_val;
                        w_next = lo_reg;
                    end
                    ACT_READ: cs_raddr = EIDX_W'(lo_reg + pos_x);
                    default: begin
                        odeg_next = len_val;
                        i_next    = '0;
                    end
                endcase
            end
            S_CT_CMP: begin
                if (cs_q == col_reg) found_next = 1'b1;
                i_next = i_reg + 1'b1;
            end
            S_RE_CAP: begin
                found_next = 1'b1;
                entry_next = cs_q;
            end
            S_DG_CMP: begin
                if (cs_q == col_reg) ideg_next = ideg_reg + 1'b1;
                i_next = i_reg + 1'b1;
            end
            // clear row: close the gap, then lower later offsets
            S_CR_RD: begin
                if (i_reg >= edges_reg) r_next = row_p1;
            end
            S_CR_WR: begin
                cs_we  = 1'b1;
                w_next = w_reg + 1'b1;
                i_next = i_reg + 1'b1;
            end
            S_CR_OFF_RD: begin
                if (r_reg >= nodes_reg) edges_next = edges_reg - (hi_reg - lo_reg);
            end
            S_CR_OFF_WR: begin
                off_we    = 1'b1;
                off_wdata = off_q - (hi_reg - lo_reg);
                r_next    = r_reg + 1'b1;
            end
            // clear column: compact in place row by row
            S_CC_ROW: begin
                off_raddr = NODE_W'(r_reg + 1'b1);
                if (r_reg >= nodes_reg) edges_next = edges_reg - ECNT_W'(rem_reg);
            end
            S_CC_HI: begin
                hi_next = cc_hi_val;
                i_next  = lo_reg;
                hit_next = 1'b0;
                if (r_reg != '0) begin
                    off_we    = 1'b1;
                    off_wdata = lo_reg - ECNT_W'(rem_reg);
                end
            end
            S_CC_RD: begin
                if (i_reg >= hi_reg) begin
                    if (hit_reg) rem_next = rem_reg + 1'b1;
                    lo_next = hi_reg;
                    r_next  = r_reg + 1'b1;
                end
            end
            S_CC_CHK: begin
                if (!hit_reg && cs_q == col_reg) begin
                    hit_next = 1'b1;
                end else begin
                    cs_we  = 1'b1;
                    w_next = w_reg + 1'b1;
                end
                i_next = i_reg + 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    md_next = {3'b000, edges_reg, nodes_reg, ideg_reg, odeg_reg,
                               entry_reg, found_reg};
                    mu_next = status_reg;
                end
            end
            default: ;
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            nodes_reg <= NCNT_W'(1);
            edges_reg <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            nodes_reg <= nodes_next;
            edges_reg <= edges_next;
            mv_reg    <= mv_next;
        end
        act_reg    <= act_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        pos_reg    <= pos_next;
        nnew_reg   <= nnew_next;
        r_reg      <= r_next;
        rem_reg    <= rem_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        i_reg      <= i_next;
        w_reg      <= w_next;
        odeg_reg   <= odeg_next;
        ideg_reg   <= ideg_next;
        hit_reg    <= hit_next;
        found_reg  <= found_next;
        entry_reg  <= entry_next;
        status_reg <= status_next;
        md_reg     <= md_next;
        mu_reg     <= mu_next;
    end

endmodule

`default_nettype wire

[test/tb_top.sv]
// ============================================================================
// tb_top
// Streaming testbench for the CSR adjacency table: directed and random
// requests, predicted results compared beat by beat on the result channel.
// ============================================================================
`timescale 1ns / 1ps

module tb_top
    import cat_pkg::*;
();

    // action code outside the defined set
    localparam logic [2:0] ACT_UNUSED = 3'd7;

    typedef struct packed {
        logic        found;
        logic [9:0]  entry_col;
        logic [12:0] out_degree;
        logic [12:0] in_degree;
        logic [10:0] node_count;
        logic [12:0] edge_count;
        logic [1:0]  status;
    } table_result_t;

    // Scoreboard: own copy of the graph, queue of predicted results
    class graph_scoreboard;
        int unsigned   offs [MAX_NODES+1];
        logic [9:0]    cols [MAX_EDGES];
        int unsigned   nodes;
        table_result_t pending [$];
        int            errors;

        function new();
            foreach (offs[i]) offs[i] = 0;
            foreach (cols[i]) cols[i] = '0;
            nodes = 1;
            errors = 0;
        endfunction

        function void note_request(logic [2:0] act, logic [9:0] row,
                                   logic [9:0] col, logic [11:0] pos);
            table_result_t r;
            int unsigned edges, lo, hi, w, removed;
            bit hit;
            r = '0;
            edges = offs[MAX_NODES];
            case (act)
                ACT_INSERT: begin
                    if (edges >= MAX_EDGES) begin
                        r.status = ST_FULL;
                    end else begin
                        if (row + 1 > nodes) nodes = row + 1;
                        if (col + 1 > nodes) nodes = col + 1;
                        hi = offs[row+1];
                        for (int i = edges; i > hi; i--) cols[i] = cols[i-1];
                        cols[hi] = col;
                        for (int i = row + 1; i <= MAX_NODES; i++) offs[i]++;
                    end
                end
                ACT_CONTAINS: begin
                    if (row >= nodes || col >= nodes) r.status = ST_RANGE;
                    else
                        for (int i = offs[row]; i < offs[row+1]; i++)
                            if (cols[i] == col) r.found = 1'b1;
                end
                ACT_CLR_ROW: begin
                    if (row >= nodes) begin
                        r.status = ST_RANGE;
                    end else begin
                        lo = offs[row];
                        hi = offs[row+1];
                        for (int i = hi; i < edges; i++) cols[lo + i - hi] = cols[i];
                        for (int i = row + 1; i <= MAX_NODES; i++)
                            offs[i] -= hi - lo;
                    end
                end
                ACT_CLR_COL: begin
                    if (col >= nodes) begin
                        r.status = ST_RANGE;
                    end else begin
                        w = 0;
                        removed = 0;
                        for (int rr = 0; rr < nodes; rr++) begin
                            hit = 0;
                            lo = offs[rr];
                            hi = offs[rr+1];
                            offs[rr] = lo - removed;
                            for (int i = lo; i < hi; i++) begin
                                if (!hit && cols[i] == col) begin
                                    hit = 1;
                                end else begin
                                    cols[w] = cols[i];
                                    w++;
                                end
                            end
                            if (hit) removed++;
                        end
                        for (int rr = nodes; rr <= MAX_NODES; rr++)
                            offs[rr] -= removed;
                    end
                end
                ACT_CLR_ALL: begin
                    foreach (offs[i]) offs[i] = 0;
                    nodes = 1;
                end
                ACT_READ: begin
                    if (row >= nodes) begin
                        r.status = ST_RANGE;
                    end else if (pos < offs[row+1] - offs[row]) begin
                        r.found = 1'b1;
                        r.entry_col = cols[offs[row] + pos];
                    end
                end
                ACT_DEGREE: begin
                    if (row >= nodes || col >= nodes) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.out_degree = 13'(offs[row+1] - offs[row]);
                        for (int i = 0; i < edges; i++)
                            if (cols[i] == col) r.in_degree++;
                    end
                end
                default: r.status = ST_RANGE;
            endcase
            r.node_count = 11'(nodes);
            r.edge_count = 13'(offs[MAX_NODES]);
            pending = {pending, r};
        endfunction

        function void check_result(logic [63:0] d, logic [1:0] st);
            table_result_t e, a;
            if (pending.size() == 0) begin
                $error("result beat with no request outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            a = {d[0], d[10:1], d[23:11], d[36:24], d[47:37], d[60:48], st};
            if (a.found !== e.found) begin
                $error("found exp %0d got %0d", e.found, a.found); errors++;
            end
            if (a.entry_col !== e.entry_col) begin
                $error("entry_col exp %0d got %0d", e.entry_col, a.entry_col); errors++;
            end
            if (a.out_degree !== e.out_degree) begin
                $error("out_degree exp %0d got %0d", e.out_degree, a.out_degree);
                errors++;
            end
            if (a.in_degree !== e.in_degree) begin
                $error("in_degree exp %0d got %0d", e.in_degree, a.in_degree); errors++;
            end
            if (a.node_count !== e.node_count) begin
                $error("node_count exp %0d got %0d", e.node_count, a.node_count);
                errors++;
            end
            if (a.edge_count !== e.edge_count) begin
                $error("edge_count exp %0d got %0d", e.edge_count, a.edge_count);
                errors++;
            end
            if (a.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, a.status); errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    graph_scoreboard sb = new();
    bit calm;          // no idling on either side
    bit sink_hold;     // long receiver hold-off
    bit stim_done;

    always #2 aclk = ~aclk;

    csr_adjacency_table uut (.*);

    // sampling at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    // receiver ready, driven at the falling edge
    always @(negedge aclk) begin
        if (!aresetn || sink_hold) m_tready <= 0;
        else m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
    end

    // offer one request beat, wait for acceptance; valid stays up so the
    // next call can follow without a gap
    task automatic send_request(logic [2:0] act, logic [9:0] row,
                                logic [9:0] col, logic [11:0] pos);
        while (!calm && $urandom_range(99) < 11) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= act;
        s_tdata  <= {pos, col, row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(act, row, col, pos);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [9:0] pick_node(int unsigned hi_n);
        return (hi_n > 0 && $urandom_range(9) < 8) ? 10'($urandom_range(hi_n - 1))
                                                   : 10'($urandom_range(1023));
    endfunction

    // stimulus
    initial begin
        logic [2:0] act;
        int unsigned span;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: every action, extremes and range cases
        send_request(ACT_READ, 0, 0, 0);
        send_request(ACT_CONTAINS, 1, 0, 0);
        send_request(ACT_INSERT, 0, 0, 0);
        send_request(ACT_INSERT, 0, 5, 0);
        send_request(ACT_INSERT, 3, 5, 0);
        send_request(ACT_INSERT, 1023, 1023, 0);
        send_request(ACT_INSERT, 2, 5, 0);
        send_request(ACT_CONTAINS, 0, 5, 0);
        send_request(ACT_CONTAINS, 0, 7, 0);
        send_request(ACT_READ, 0, 0, 1);
        send_request(ACT_READ, 0, 0, 4095);
        send_request(ACT_READ, 1023, 1023, 0);
        send_request(ACT_DEGREE, 0, 5, 0);
        send_request(ACT_DEGREE, 1023, 1023, 0);
        send_request(ACT_CLR_COL, 0, 5, 0);
        send_request(ACT_CLR_ROW, 1023, 0, 0);
        send_request(ACT_CLR_ROW, 0, 0, 0);
        send_request(ACT_UNUSED, 1023, 1023, 4095);
        send_request(ACT_CLR_ALL, 0, 0, 0);
        send_request(ACT_CLR_ROW, 1, 0, 0);
        send_request(ACT_CLR_COL, 0, 1, 0);
        send_request(ACT_DEGREE, 5, 0, 0);
        wait_drained();

        // sink holds off while requests keep coming
        fork
            begin
                sink_hold = 1;
                repeat (2000) @(posedge aclk);
                sink_hold = 0;
            end
            for (int i = 0; i < 8; i++)
                send_request(ACT_INSERT, 10'($urandom_range(7)), 10'($urandom_range(7)), 0);
        join
        wait_drained();

        // random: mostly inserts and queries in a small node range
        for (int i = 0; i < 100; i++) begin
            calm = (i >= 40 && i < 70);
            span = (i < 70) ? 16 : 64;
            case ($urandom_range(99)) inside
                [0:44]:  act = ACT_INSERT;
                [45:56]: act = ACT_CONTAINS;
                [57:64]: act = ACT_CLR_ROW;
                [65:71]: act = ACT_CLR_COL;
                [72:73]: act = ACT_CLR_ALL;
                [74:85]: act = ACT_READ;
                [86:97]: act = ACT_DEGREE;
                default: act = ACT_UNUSED;
            endcase
            send_request(act, pick_node(span), pick_node(span),
                         $urandom_range(9) < 8 ? 12'($urandom_range(7))
                                               : 12'($urandom_range(4095)));
        end
        calm = 0;

        // clear, then requests on an empty graph
        send_request(ACT_CLR_ALL, 0, 0, 0);
        wait_drained();
        calm = 1;
        send_request(ACT_DEGREE, 1023, 1023, 0);
        send_request(ACT_READ, 1020, 0, 1023);
        send_request(ACT_CLR_ROW, 1021, 0, 0);
        send_request(ACT_CLR_COL, 0, 1023, 0);
        s_tvalid <= 0;
        calm = 0;
        stim_done = 1;
    end

    // end of run
    initial begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #200ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/cat_pkg.sv
hw/rtl/cat_ram.sv
hw/rtl/csr_adjacency_table.sv
test/tb_top.sv
